### hdl/sm3hc_pkg.sv
// ---------------------------------------------------------------------------
// sm3hc_pkg
// Shared types, constants and functions of the SM3 hash core.
// ---------------------------------------------------------------------------
package sm3hc_pkg;

	localparam int unsigned NUM_IV = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [31:0] IV_RESET [NUM_IV] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [31:0] PAD_ONE = 32'h80000000;
	localparam logic [3:0]  LEN_SLOT = 4'd14;

	typedef struct packed {
		logic [31:0] message_word;
		logic [3:0]  valid_nibbles;
		logic        is_final;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// word handed from the front end to the compression engine
	typedef struct packed {
		logic [31:0] data;
		logic        first;   // first word of a message: load IV
		logic        last;    // last word of the padded message
	} blk_word_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
		logic [63:0] d;
		d = {x, x} << k;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
	endfunction

endpackage

### hdl/sm3hc_front.sv
// ---------------------------------------------------------------------------
// sm3hc_front
// Takes message words, counts bits and generates the padding words.
// ---------------------------------------------------------------------------
module sm3hc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sm3hc_pkg::in_item_t   in_item,
	output logic                  wr_en,
	output sm3hc_pkg::blk_word_t  wr_word,
	input  logic                  q_full
);
	import sm3hc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ZERO = 4'b0010,
		ST_LENH = 4'b0100,
		ST_LENL = 4'b1000
	} fst_t;

	fst_t        state_q;
	logic [63:0] bits_q;
	logic [3:0]  fill_q;
	logic        in_msg_q;
	logic        extra_one_q;

	logic [3:0]  nib;
	logic [31:0] mask;
	logic [63:0] bits_nxt;
	logic        acc;

	always_comb begin
		nib = (in_item.valid_nibbles > 4'd8) ? 4'd8 : in_item.valid_nibbles;
		if (!in_item.is_final) nib = 4'd8;
		mask = (nib == 4'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nib, 2'b00}));
		bits_nxt = (in_msg_q ? bits_q : 64'd0) + {58'd0, nib, 2'b00};
	end

	assign full = (state_q != ST_IDLE) || q_full;
	assign acc  = push && !full;

	always_comb begin
		wr_en = 1'b0;
		wr_word = '0;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = acc;
				wr_word.first = !in_msg_q;
				if (!in_item.is_final || nib == 4'd8)
					wr_word.data = in_item.message_word;
				else
					wr_word.data = (in_item.message_word & mask) | (PAD_ONE >> {nib, 2'b00});
			end
			ST_ZERO: begin
				wr_en = !q_full;
				wr_word.data = extra_one_q ? PAD_ONE : 32'h0;
			end
			ST_LENH: begin
				wr_en = !q_full;
				wr_word.data = bits_q[63:32];
			end
			ST_LENL: begin
				wr_en = !q_full;
				wr_word.data = bits_q[31:0];
				wr_word.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q <= '0;
			fill_q <= '0;
			in_msg_q <= 1'b0;
			extra_one_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						bits_q <= bits_nxt;
						fill_q <= (in_msg_q ? fill_q : 4'd0) + 4'd1;
						in_msg_q <= !in_item.is_final;
						if (in_item.is_final) begin
							extra_one_q <= (nib == 4'd8);
							if (nib == 4'd8 ||
							    ((in_msg_q ? fill_q : 4'd0) + 4'd1) != LEN_SLOT)
								state_q <= ST_ZERO;
							else
								state_q <= ST_LENH;
						end
					end
				end
				ST_ZERO: begin
					if (!q_full) begin
						extra_one_q <= 1'b0;
						fill_q <= fill_q + 4'd1;
						if (fill_q + 4'd1 == LEN_SLOT) state_q <= ST_LENH;
					end
				end
				ST_LENH: if (!q_full) state_q <= ST_LENL;
				ST_LENL: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
						fill_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/sm3hc_fifo.sv
// ---------------------------------------------------------------------------
// sm3hc_fifo
// Short word queue between front end and compression engine.
// ---------------------------------------------------------------------------
module sm3hc_fifo #(
	parameter int unsigned DEPTH = sm3hc_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  sm3hc_pkg::blk_word_t  wr_word,
	output logic                  q_full,
	input  logic                  rd_en,
	output sm3hc_pkg::blk_word_t  rd_word,
	output logic                  q_empty
);
	import sm3hc_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	blk_word_t   mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign q_empty = (wp_q == rp_q);
	assign q_full  = (wp_q[AW-1:0] == rp_q[AW-1:0]) && (wp_q[AW] != rp_q[AW]);
	assign rd_word = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en && !q_full) mem_q[wp_q[AW-1:0]] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_en && !q_full) wp_q <= wp_q + 1'b1;
			if (rd_en && !q_empty) rp_q <= rp_q + 1'b1;
		end
	end

endmodule

### hdl/sm3hc_engine.sv
// ---------------------------------------------------------------------------
// sm3hc_engine
// Fills the block buffer, runs 64 rounds per block and emits the digest.
// ---------------------------------------------------------------------------
module sm3hc_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           iv [sm3hc_pkg::NUM_IV],
	input  sm3hc_pkg::blk_word_t  rd_word,
	input  logic                  q_empty,
	output logic                  rd_en,
	output logic                  empty,
	input  logic                  pop,
	output sm3hc_pkg::out_item_t  out_item
);
	import sm3hc_pkg::*;

	typedef enum logic [2:0] {
		ST_FILL = 3'b001,
		ST_RND  = 3'b010,
		ST_OUT  = 3'b100
	} est_t;

	est_t        state_q;
	logic [31:0] cv_q [8];
	logic [31:0] r_q [8];
	logic [31:0] w_q [16];
	logic [3:0]  fill_q;
	logic [5:0]  rnd_q;
	logic        last_blk_q;
	logic [2:0]  oidx_q;

	logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, wn;
	logic        lo;

	always_comb begin
		lo  = (rnd_q < 6'd16);
		tj  = lo ? T_LOW : T_HIGH;
		a12 = rotl(r_q[0], 5'd12);
		ss1 = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (lo) begin
			ffv = r_q[0] ^ r_q[1] ^ r_q[2];
			ggv = r_q[4] ^ r_q[5] ^ r_q[6];
		end else begin
			ffv = (r_q[0] & r_q[1]) | (r_q[1] & r_q[2]) | (r_q[2] & r_q[0]);
			ggv = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
		end
		tt1 = ffv + r_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = ggv + r_q[7] + ss1 + w_q[0];
		wn  = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	assign rd_en = (state_q == ST_FILL) && !q_empty;
	assign empty = (state_q != ST_OUT);
	assign out_item.digest_word = cv_q[oidx_q];
	assign out_item.word_index  = oidx_q;
	assign out_item.last_word   = (oidx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			rnd_q <= '0;
			last_blk_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= IV_RESET[i];
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (!q_empty) begin
						if (rd_word.first) for (int i = 0; i < 8; i++) cv_q[i] <= iv[i];
						fill_q <= fill_q + 4'd1;
						if (fill_q == 4'd15) begin
							state_q <= ST_RND;
							last_blk_q <= rd_word.last;
							rnd_q <= '0;
							for (int i = 0; i < 8; i++)
								r_q[i] <= rd_word.first ? iv[i] : cv_q[i];
						end
					end
				end
				ST_RND: begin
					r_q[3] <= r_q[2];
					r_q[2] <= rotl(r_q[1], 5'd9);
					r_q[1] <= r_q[0];
					r_q[0] <= tt1;
					r_q[7] <= r_q[6];
					r_q[6] <= rotl(r_q[5], 5'd19);
					r_q[5] <= r_q[4];
					r_q[4] <= perm0(tt2);
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cv_q[0] <= cv_q[0] ^ tt1;
						cv_q[1] <= cv_q[1] ^ r_q[0];
						cv_q[2] <= cv_q[2] ^ rotl(r_q[1], 5'd9);
						cv_q[3] <= cv_q[3] ^ r_q[2];
						cv_q[4] <= cv_q[4] ^ perm0(tt2);
						cv_q[5] <= cv_q[5] ^ r_q[4];
						cv_q[6] <= cv_q[6] ^ rotl(r_q[5], 5'd19);
						cv_q[7] <= cv_q[7] ^ r_q[6];
						oidx_q <= '0;
						state_q <= last_blk_q ? ST_OUT : ST_FILL;
					end
				end
				ST_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) state_q <= ST_FILL;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	// block buffer doubles as the expansion window: shifts one word per step
	always_ff @(posedge clk) begin
		if (state_q == ST_FILL && !q_empty) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= rd_word.data;
		end else if (state_q == ST_RND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

endmodule

### hdl/sm3_hash_core_top.sv
// ---------------------------------------------------------------------------
// sm3_hash_core_top
// SM3 hash core: message words in, eight digest words out.
// ---------------------------------------------------------------------------
// channel   signals                         transfer when
// input     push, full, in_item             push & !full
// result    empty, pop, out_item            pop & !empty
// config    cfg_valid, cfg_ready, cfg_*     cfg_valid & cfg_ready
//
// Each 16-word block is loaded into the buffer and then run through 64 rounds in
// the single round unit. Padding words come from the front end, up to 18
// words after a final word. A 4-entry queue lets the front end take words
// while the engine runs rounds. Eight digest pops end a message.
// Reset loads the standard IV and clears all control state.
module sm3_hash_core_top #(
	parameter int unsigned QDEPTH = sm3hc_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  sm3hc_pkg::in_item_t               in_item,
	output logic                              empty,
	input  logic                              pop,
	output sm3hc_pkg::out_item_t              out_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sm3hc_pkg::CFG_IDX_W:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);
	import sm3hc_pkg::*;

	logic [31:0] iv_q [NUM_IV];
	logic        wr_en, q_full, rd_en, q_empty;
	blk_word_t   wr_word, rd_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_IV; i++) iv_q[i] <= IV_RESET[i];
		end else if (cfg_valid && !cfg_index[CFG_IDX_W]) begin
			iv_q[cfg_index[CFG_IDX_W-1:0]] <= cfg_data;
		end
	end

	sm3hc_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.wr_en, .wr_word, .q_full
	);

	sm3hc_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk, .arst_n, .wr_en, .wr_word, .q_full,
		.rd_en, .rd_word, .q_empty
	);

	sm3hc_engine u_engine (
		.clk, .arst_n, .iv(iv_q), .rd_word, .q_empty, .rd_en,
		.empty, .pop, .out_item
	);

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !out_item.last_word) |=> !empty)
		else $error("digest burst broken");
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.last_word) |-> out_item.word_index == 3'd7)
		else $error("last flag on wrong word");
	a_no_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && q_full))
		else $error("queue overrun");

endmodule
